// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine: request and result
// items, action and status codes, and the controller-to-datapath link.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int POS_W     = 11;
  localparam int ST_W      = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PRIOR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd5;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd6;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // read sweep modes
  localparam logic [1:0] RD_SCAN = 2'd0;  // 0 .. fill-1, ascending
  localparam logic [1:0] RD_GET  = 2'd1;  // pos-1 only
  localparam logic [1:0] RD_DEL  = 2'd2;  // pos-1 .. fill-1, ascending
  localparam logic [1:0] RD_INS  = 2'd3;  // fill-1 .. pos-1, descending

  // memory write sources
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_UP   = 2'd1;  // read word to tag+1
  localparam logic [1:0] WR_DOWN = 2'd2;  // read word to tag-1
  localparam logic [1:0] WR_VAL  = 2'd3;  // request value to pos-1

  // fill counter ops
  localparam logic [1:0] FILL_KEEP = 2'd0;
  localparam logic [1:0] FILL_CLR  = 2'd1;
  localparam logic [1:0] FILL_INC  = 2'd2;
  localparam logic [1:0] FILL_DEC  = 2'd3;

  // result register updates
  localparam logic [2:0] RES_NONE  = 3'd0;
  localparam logic [2:0] RES_OK    = 3'd1;
  localparam logic [2:0] RES_BAD   = 3'd2;
  localparam logic [2:0] RES_FULL  = 3'd3;
  localparam logic [2:0] RES_RDATA = 3'd4;
  localparam logic [2:0] RES_PREV  = 3'd5;
  localparam logic [2:0] RES_LOC   = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         count;
    logic                     is_empty;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       rd_init;
    logic [1:0] rd_mode;
    logic       rd_stop;
    logic [1:0] wr_op;
    logic [1:0] fill_op;
    logic [2:0] res_op;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             pos_ok;
    logic             ins_ok;
    logic             ins_tail;
    logic             full;
    logic             empty;
    logic             dvld;
    logic             dfirst;
    logic             dlast;
    logic             hit_cur;
    logic             hit_prev;
    logic             prev_vld;
  } stat_t;

endpackage

// ===== rtl/sle_dp.sv =====
// ----------------------------------------------------------------------------
// sle_dp
// Datapath: word store, fill counter, read sweep pointer, compare flags,
// result and output registers.
// ----------------------------------------------------------------------------
module sle_dp import sle_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t st,
  output rsp_t  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [ACT_W-1:0]  act;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  logic [CW-1:0]     fill;

  logic [AW-1:0]     ptr;
  logic [AW-1:0]     end_ptr;
  logic              dir_down;
  logic              rd_active;
  logic              rd_first;
  logic              dvld;
  logic              dfirst;
  logic              dlast;
  logic [AW-1:0]     tag;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] prev_data;
  logic              prev_vld;

  logic [ST_W-1:0]   res_status;
  logic [DATA_W-1:0] res_data;
  logic [POS_W-1:0]  res_found;

  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     fill_x;
  logic [AW-1:0]     pos_m1;
  logic [AW-1:0]     fill_m1;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign pos_x   = XW'(pos);
  assign fill_x  = XW'(fill);
  assign pos_m1  = AW'(pos - POS_W'(1));
  assign fill_m1 = AW'(fill - CW'(1));

  // status to controller
  always_comb begin
    st.act      = act;
    st.pos_ok   = (pos_x != '0) && (pos_x <= fill_x);
    st.ins_ok   = (pos_x != '0) && (pos_x <= fill_x + XW'(1));
    st.ins_tail = (pos_x == fill_x + XW'(1));
    st.full     = (fill_x == XW'(DEPTH));
    st.empty    = (fill == '0);
    st.dvld     = dvld;
    st.dfirst   = dfirst;
    st.dlast    = dlast;
    st.hit_cur  = (rdata == val);
    st.hit_prev = prev_vld && (prev_data == val);
    st.prev_vld = prev_vld;
  end

  // write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = tag;
    wr_data = rdata;
    case (cmd.wr_op)
      WR_UP:   wr_addr = tag + AW'(1);
      WR_DOWN: wr_addr = tag - AW'(1);
      WR_VAL: begin
        wr_addr = pos_m1;
        wr_data = val;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_active) begin
      rdata <= mem[ptr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= req.action;
      pos <= req.position;
      val <= req.value;
    end
  end

  // fill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      case (cmd.fill_op)
        FILL_CLR: fill <= '0;
        FILL_INC: fill <= fill + CW'(1);
        FILL_DEC: fill <= fill - CW'(1);
        default:  fill <= fill;
      endcase
    end
  end

  // read sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active <= 1'b0;
      dvld      <= 1'b0;
    end else begin
      dvld <= rd_active;
      if (cmd.rd_init) begin
        rd_active <= 1'b1;
      end else if (cmd.rd_stop || (rd_active && ptr == end_ptr)) begin
        rd_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_init) begin
      rd_first <= 1'b1;
      prev_vld <= 1'b0;
      dir_down <= 1'b0;
      case (cmd.rd_mode)
        RD_SCAN: begin
          ptr     <= '0;
          end_ptr <= fill_m1;
        end
        RD_GET: begin
          ptr     <= pos_m1;
          end_ptr <= pos_m1;
        end
        RD_DEL: begin
          ptr     <= pos_m1;
          end_ptr <= fill_m1;
        end
        default: begin
          ptr      <= fill_m1;
          end_ptr  <= pos_m1;
          dir_down <= 1'b1;
        end
      endcase
    end else begin
      if (rd_active) begin
        tag      <= ptr;
        dfirst   <= rd_first;
        dlast    <= (ptr == end_ptr);
        rd_first <= 1'b0;
        ptr      <= dir_down ? ptr - AW'(1) : ptr + AW'(1);
      end
      if (dvld) begin
        prev_data <= rdata;
        prev_vld  <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    case (cmd.res_op)
      RES_OK: begin
        res_status <= ST_OK;
        res_data   <= '0;
        res_found  <= '0;
      end
      RES_BAD: begin
        res_status <= ST_BAD;
        res_data   <= '0;
        res_found  <= '0;
      end
      RES_FULL: begin
        res_status <= ST_FULL;
        res_data   <= '0;
        res_found  <= '0;
      end
      RES_RDATA: begin
        res_status <= ST_OK;
        res_data   <= rdata;
        res_found  <= '0;
      end
      RES_PREV: begin
        res_status <= ST_OK;
        res_data   <= prev_data;
        res_found  <= '0;
      end
      RES_LOC: begin
        res_status <= ST_OK;
        res_data   <= '0;
        res_found  <= POS_W'({1'b0, tag} + (AW + 1)'(1));
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // output register; count taken after the fill update
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status         <= res_status;
      rsp.data_out       <= res_data;
      rsp.found_position <= res_found;
      rsp.count          <= POS_W'(fill);
      rsp.is_empty       <= (fill == '0);
    end
  end

endmodule

// ===== rtl/sle_ctrl.sv =====
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: sequences one request through dispatch, read sweep, shift
// writes and result hand-off.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_GET       = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_INS_SHIFT = 3'd4;
  localparam logic [2:0] S_INS_WRITE = 3'd5;
  localparam logic [2:0] S_DEL       = 3'd6;
  localparam logic [2:0] S_RESP      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       hit;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    hit = ((st.act == ACT_LOCATE) && st.hit_cur) ||
          ((st.act == ACT_PRIOR) && st.hit_cur && st.prev_vld) ||
          ((st.act == ACT_NEXT) && st.hit_prev);
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_RESP;
        case (st.act)
          ACT_CLEAR: begin
            cmd.fill_op = FILL_CLR;
            cmd.res_op  = RES_OK;
          end
          ACT_GET: begin
            if (st.pos_ok) begin
              cmd.rd_init = 1'b1;
              cmd.rd_mode = RD_GET;
              state_next  = S_GET;
            end else begin
              cmd.res_op = RES_BAD;
            end
          end
          ACT_LOCATE, ACT_PRIOR, ACT_NEXT: begin
            if (st.empty) begin
              cmd.res_op = RES_BAD;
            end else begin
              cmd.rd_init = 1'b1;
              cmd.rd_mode = RD_SCAN;
              state_next  = S_SCAN;
            end
          end
          ACT_INSERT: begin
            if (!st.ins_ok) begin
              cmd.res_op = RES_BAD;
            end else if (st.full) begin
              cmd.res_op = RES_FULL;
            end else if (st.ins_tail) begin
              state_next = S_INS_WRITE;
            end else begin
              cmd.rd_init = 1'b1;
              cmd.rd_mode = RD_INS;
              state_next  = S_INS_SHIFT;
            end
          end
          ACT_DELETE: begin
            if (st.pos_ok) begin
              cmd.rd_init = 1'b1;
              cmd.rd_mode = RD_DEL;
              state_next  = S_DEL;
            end else begin
              cmd.res_op = RES_BAD;
            end
          end
          default: begin
            cmd.res_op = RES_BAD;
          end
        endcase
      end
      S_GET: begin
        if (st.dvld) begin
          cmd.res_op = RES_RDATA;
          state_next = S_RESP;
        end
      end
      S_SCAN: begin
        if (st.dvld) begin
          if (hit) begin
            cmd.rd_stop = 1'b1;
            state_next  = S_RESP;
            if (st.act == ACT_LOCATE) begin
              cmd.res_op = RES_LOC;
            end else if (st.act == ACT_PRIOR) begin
              cmd.res_op = RES_PREV;
            end else begin
              cmd.res_op = RES_RDATA;
            end
          end else if (st.dlast) begin
            cmd.res_op = RES_BAD;
            state_next = S_RESP;
          end
        end
      end
      S_INS_SHIFT: begin
        if (st.dvld) begin
          cmd.wr_op = WR_UP;
          if (st.dlast) begin
            state_next = S_INS_WRITE;
          end
        end
      end
      S_INS_WRITE: begin
        cmd.wr_op   = WR_VAL;
        cmd.fill_op = FILL_INC;
        cmd.res_op  = RES_OK;
        state_next  = S_RESP;
      end
      S_DEL: begin
        if (st.dvld) begin
          if (st.dfirst) begin
            cmd.res_op = RES_RDATA;
          end else begin
            cmd.wr_op = WR_DOWN;
          end
          if (st.dlast) begin
            cmd.fill_op = FILL_DEC;
            state_next  = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sequential_list_engine.sv =====
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed words in a single-port-write / single-port-read
// store, reached by 1-based position: clear, get, locate, prior, next,
// insert and delete, one result item per request item.
// ----------------------------------------------------------------------------
//
//   channel | signals                   | item
//   --------+---------------------------+--------------------------------
//   request | req_valid, req_ready, req | action, position, value
//   result  | rsp_valid, rsp_ready, rsp | status, data_out, found_position,
//           |                           | count, is_empty
//
// Work per item, from request accept to result ready:
//   clear and rejected requests: no walk; get: one word read;
//   locate / prior / next: number of words visited (at most fill);
//   insert: a direct write at the tail, else (fill - position + 1) tail moves;
//   delete: (fill - position + 1) words read. The store's one read and
//   one write port per cycle set the walk rate: one word per cycle.
// Reset clears the fill count and the control state; the store is not
//   cleared, since only words below the fill count are ever read.
// A new request is taken as soon as the previous result sits in the output
//   register, even while the consumer stalls; the next result waits in S_RESP.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // command and status link between controller and datapath
  cmd_t  cmd;
  stat_t st;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .st        (st),
    .cmd       (cmd)
  );

  sle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .st  (st),
    .rsp (rsp)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequential_list_engine. A software copy of the list
// predicts every result item. Named tests cover the edge cases, a full store,
// a long consumer stall and mixed random traffic with random idle on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
  import sle_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;   // worst item: longest walk plus stalls
  localparam int TAIL_CYCLES = 1100;      // longest walk plus margin
  localparam int MAX_REPORTS = 40;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  sequential_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // Shadow copy of the list, advanced once per accepted request item.
  logic signed [DATA_W-1:0] list_words [LIST_DEPTH];
  int list_len = 0;
  rsp_t pending_rsps[$];

  // Traffic knobs shared by the sender, the receiver and the tests.
  bit idle_en = 1'b1;
  int hold_off_req = 0;

  // Run statistics.
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int peak_len = 0;
  int full_rejects = 0;
  int locate_hits = 0;
  logic signed [DATA_W-1:0] value_pool [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the result of one request and updates the shadow list.
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int p;
    int k;
    logic signed [DATA_W-1:0] gone;
    res = '0;
    res.status = ST_OK;
    p = int'(r.position);
    case (r.action)
      ACT_CLEAR: list_len = 0;
      ACT_GET: begin
        if (p < 1 || p > list_len) res.status = ST_BAD;
        else res.data_out = list_words[p-1];
      end
      ACT_LOCATE: begin
        res.status = ST_BAD;
        for (k = 0; k < list_len && res.status == ST_BAD; k++) begin
          if (list_words[k] == r.value) begin
            res.status = ST_OK;
            res.found_position = POS_W'(k + 1);
          end
        end
        if (res.status == ST_OK) locate_hits++;
      end
      ACT_PRIOR: begin
        // first match at index 1 or later gives its predecessor
        res.status = ST_BAD;
        for (k = 1; k < list_len && res.status == ST_BAD; k++) begin
          if (list_words[k] == r.value) begin
            res.status = ST_OK;
            res.data_out = list_words[k-1];
          end
        end
      end
      ACT_NEXT: begin
        // first match that still has a successor
        res.status = ST_BAD;
        for (k = 0; k + 1 < list_len && res.status == ST_BAD; k++) begin
          if (list_words[k] == r.value) begin
            res.status = ST_OK;
            res.data_out = list_words[k+1];
          end
        end
      end
      ACT_INSERT: begin
        // range check wins over the full check
        if (p < 1 || p > list_len + 1) begin
          res.status = ST_BAD;
        end else if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
          full_rejects++;
        end else begin
          for (k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = r.value;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (p < 1 || p > list_len) begin
          res.status = ST_BAD;
        end else begin
          gone = list_words[p-1];
          for (k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
          res.data_out = gone;
        end
      end
      default: res.status = ST_BAD;
    endcase
    res.count = POS_W'(list_len);
    res.is_empty = (list_len == 0);
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  // Offers one request item and holds it until accepted. Called and returns
  // at a falling edge; valid stays high so back-to-back items have no bubble.
  task automatic send(logic [ACT_W-1:0] action, int position, logic [DATA_W-1:0] value);
    req_t item;
    int gap;
    item.action = action;
    item.position = POS_W'(position);
    item.value = value;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsps.push_back(apply_request(item));
    items_sent++;
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic report_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Edge cases on a short list: empty-list rejects, extreme words, first-match
  // rules for prior and next, the unused action and an all-ones position.
  task automatic test_short_list();
    send(ACT_GET, 1, 0);
    send(ACT_DELETE, 1, 0);
    send(ACT_LOCATE, 0, 0);
    send(ACT_PRIOR, 0, 0);
    send(ACT_NEXT, 0, 0);
    send(ACT_INSERT, 0, 32'h1234_5678);
    send(ACT_INSERT, 2, 32'h1234_5678);
    send(ACT_INSERT, 1, 32'h8000_0000);
    send(ACT_INSERT, 2, 32'h7fff_ffff);
    send(ACT_INSERT, 1, 32'h0000_0000);
    send(ACT_INSERT, 4, 32'hffff_ffff);
    send(ACT_INSERT, 3, 32'h0000_0000);   // duplicate zero further in
    send(ACT_GET, 0, 0);
    send(ACT_GET, 6, 0);
    send(ACT_GET, 5, 0);
    send(ACT_LOCATE, 0, 32'h0000_0000);    // first of two zeros
    send(ACT_LOCATE, 0, 32'h8000_0001);    // absent
    send(ACT_PRIOR, 0, 32'h0000_0000);     // skips index 0, hits the duplicate
    send(ACT_PRIOR, 0, 32'h8000_0000);
    send(ACT_NEXT, 0, 32'hffff_ffff);      // last word has no successor
    send(ACT_NEXT, 0, 32'h7fff_ffff);
    send(ACT_UNUSED, 2047, 32'hffff_ffff);
    send(ACT_DELETE, 6, 0);
    send(ACT_DELETE, 2, 0);
    send(ACT_CLEAR, 0, 0);
    wait_for_results();
  endtask

  // Fills the store to DEPTH words, then hits the full and range limits and
  // the longest tail moves and walks.
  task automatic test_full_store();
    send(ACT_CLEAR, 0, 0);
    while (list_len < LIST_DEPTH) send(ACT_INSERT, list_len + 1, $urandom);
    send(ACT_INSERT, LIST_DEPTH + 1, 32'h5555_5555);   // full
    send(ACT_INSERT, 1, 32'haaaa_aaaa);                // full
    send(ACT_INSERT, LIST_DEPTH + 2, 0);              // range before full
    send(ACT_INSERT, 2047, 0);
    send(ACT_GET, LIST_DEPTH, 0);
    send(ACT_GET, LIST_DEPTH + 1, 0);
    send(ACT_LOCATE, 0, list_words[LIST_DEPTH-1]);
    send(ACT_NEXT, 0, list_words[LIST_DEPTH-2]);
    send(ACT_DELETE, LIST_DEPTH, 0);
    send(ACT_INSERT, 1, 32'h8000_0000);               // moves the whole tail
    send(ACT_PRIOR, 0, list_words[LIST_DEPTH-1]);
    send(ACT_DELETE, 1, 0);                           // shifts the whole tail
    send(ACT_CLEAR, 0, 0);
    send(ACT_GET, 1, 0);
    wait_for_results();
  endtask

  // The consumer stops for a long stretch while requests keep coming, so the
  // output register fills and the request side must stall.
  task automatic test_consumer_stall();
    idle_en = 1'b0;
    hold_off_req = 300;
    @(negedge clk);
    for (int i = 0; i < 24; i++) send(ACT_INSERT, $urandom_range(1, list_len + 1), $urandom);
    wait_for_results();
    idle_en = 1'b1;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    return ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
  endfunction

  // Mixed traffic. Most items are legal with positions inside the list and
  // values from a small pool so searches hit; a few are pure noise. The list
  // is steered to stay short so walks remain cheap.
  task automatic test_random_traffic(int n_items);
    int pick;
    int ins_w;
    int del_w;
    logic [ACT_W-1:0] action;
    int position;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'hffff_ffff;
    value_pool[3] = 32'h0000_0000;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items - 100) idle_en = 1'b0;   // quiet stretch at the end
      if ($urandom_range(0, 99) < 8) begin
        send(ACT_W'($urandom_range(0, 7)), $urandom_range(0, 2047), $urandom);
      end else begin
        ins_w = (list_len < 40) ? 30 : 10;
        del_w = (list_len < 40) ? 18 : 38;
        pick = $urandom_range(0, 51 + ins_w + del_w);
        if (pick < 2) action = ACT_CLEAR;
        else if (pick < 14) action = ACT_GET;
        else if (pick < 26) action = ACT_LOCATE;
        else if (pick < 39) action = ACT_PRIOR;
        else if (pick < 52) action = ACT_NEXT;
        else if (pick < 52 + ins_w) action = ACT_INSERT;
        else action = ACT_DELETE;
        if (action == ACT_INSERT) position = $urandom_range(1, list_len + 1);
        else if ($urandom_range(0, 9) == 0) position = list_len + 1;  // just past the end
        else position = (list_len == 0) ? 1 : $urandom_range(1, list_len);
        send(action, position, pick_value());
      end
    end
    wait_for_results();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (hold_off_req != 0) begin
        stall_left = hold_off_req - 1;
        hold_off_req = 0;
        rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest prediction.
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
        end else begin
          want = pending_rsps.pop_front();
          report_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
          report_field("data_out", want.data_out, rsp.data_out);
          report_field("found_position", DATA_W'(want.found_position),
                       DATA_W'(rsp.found_position));
          report_field("count", DATA_W'(want.count), DATA_W'(rsp.count));
          report_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp.is_empty));
          results_checked++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either side.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog expired with %0d results outstanding",
             $time, pending_rsps.size());
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_short_list();
    test_full_store();
    test_consumer_stall();
    test_random_traffic(550);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results checked; list peaked at %0d words", items_sent,
             results_checked, peak_len);
    $display("%0d full-store rejects, %0d locate hits, mismatches: %0d", full_rejects,
             locate_hits, errors);
    if (errors == 0 && pending_rsps.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
